// ----- hdl/ept_pkg.sv -----
// shared types, constants and the arctangent table of the ellipse tessellator
package ept_pkg;

    typedef struct packed {
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic signed [31:0] box_w;
        logic signed [31:0] box_h;
    } t_ept_in;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [5:0]         vertex_number;
        logic               last_vertex;
    } t_ept_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ZMUL,
        ST_CORDIC,
        ST_ROT,
        ST_MUL,
        ST_OFF,
        ST_EMIT
    } t_ept_state;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ALPHA    = 2'd2;

    localparam logic [5:0] DIV_LAST    = 6'd32;
    localparam logic [5:0] CORDIC_LAST = 6'd29;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic [31:0] TWO_Q16 = 32'h0002_0000;

    typedef struct packed {
        logic       load_box;
        logic       div_step;
        logic       zmul;
        logic       cordic_step;
        logic       rot;
        logic       mul;
        logic       off;
        logic       emit;
        logic [5:0] k;
    } t_ept_cmd;

    typedef struct packed {
        logic drop;
        logic thin;
        logic corner;
        logic last;
        logic out_free;
    } t_ept_stat;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sh3243F6A8;
            5'd1:  v = 32'sh1DAC6705;
            5'd2:  v = 32'sh0FADBAFC;
            5'd3:  v = 32'sh07F56EA6;
            5'd4:  v = 32'sh03FEAB76;
            5'd5:  v = 32'sh01FFD55B;
            5'd6:  v = 32'sh00FFFAAA;
            5'd7:  v = 32'sh007FFF55;
            5'd8:  v = 32'sh003FFFEA;
            5'd9:  v = 32'sh001FFFFD;
            5'd10: v = 32'sh000FFFFF;
            5'd11: v = 32'sh0007FFFF;
            5'd12: v = 32'sh0003FFFF;
            5'd13: v = 32'sh0001FFFF;
            5'd14: v = 32'sh0000FFFF;
            5'd15: v = 32'sh00007FFF;
            5'd16: v = 32'sh00003FFF;
            5'd17: v = 32'sh00001FFF;
            5'd18: v = 32'sh00000FFF;
            5'd19: v = 32'sh000007FF;
            5'd20: v = 32'sh000003FF;
            5'd21: v = 32'sh000001FF;
            5'd22: v = 32'sh000000FF;
            5'd23: v = 32'sh0000007F;
            5'd24: v = 32'sh0000003F;
            5'd25: v = 32'sh0000001F;
            5'd26: v = 32'sh0000000F;
            5'd27: v = 32'sh00000008;
            5'd28: v = 32'sh00000004;
            5'd29: v = 32'sh00000002;
            default: v = 32'sh0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/ellipse_polygon_tessellator.sv -----
// top level of the ellipse polygon tessellator
// Each request is a bounding box in Q16.16; the block answers with polygon vertices
// offset by the origin registers. With alpha zero or a box side not positive nothing
// comes out; the request is taken and the block stays idle. A box side of 2.0 or less
// gives the four corners at one vertex a cycle while the output is not stalled. Otherwise
// an ellipse of n vertices first divides one full turn by n, then per vertex runs one
// angle multiply, a 30-step cordic, rotation, scaling multiply, rounding and output, with
// n up to MAX_VERTICES; the shared cordic sets the pace. One request is worked at a time;
// the output register lets the next vertex compute while one waits.
module ellipse_polygon_tessellator #(
    parameter int MAX_VERTICES = 64,
    parameter int MIN_VERTICES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    // box requests
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ept_pkg::t_ept_in  i_in_data,
    // vertex results
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ept_pkg::t_ept_out o_out_data
);
    import ept_pkg::*;

    t_ept_cmd  w_cmd;
    t_ept_stat w_stat;

    // controller: walks division, cordic and emit steps
    ept_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: registers, arithmetic and the output register
    ept_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MIN_VERTICES (MIN_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/ept_ctrl.sv -----
// sequencing state machine of the ellipse tessellator
module ept_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ept_pkg::t_ept_stat i_stat,
    output ept_pkg::t_ept_cmd  o_cmd
);
    import ept_pkg::*;

    t_ept_state r_state, n_state;
    logic [5:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_box = 1'b1;
                    n_k = '0;
                    if (i_stat.drop) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.thin) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_k == DIV_LAST) begin
                    n_k     = '0;
                    n_state = ST_ZMUL;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end
            ST_ZMUL: begin
                o_cmd.zmul = 1'b1;
                n_k        = '0;
                n_state    = ST_CORDIC;
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_k == CORDIC_LAST) begin
                    n_k     = '0;
                    n_state = ST_ROT;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end
            ST_ROT: begin
                o_cmd.rot = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_OFF;
            end
            ST_OFF: begin
                o_cmd.off = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.corner) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_ZMUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/ept_datapath.sv -----
// datapath: vertex count, phase divider, cordic, scaling and output register
module ept_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int MIN_VERTICES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  ept_pkg::t_ept_in  i_in_data,
    input  ept_pkg::t_ept_cmd i_cmd,
    output ept_pkg::t_ept_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ept_pkg::t_ept_out o_out_data
);
    import ept_pkg::*;

    localparam logic [13:0] MIN_N = 14'(MIN_VERTICES);
    localparam logic [13:0] MAX_N = 14'(MAX_VERTICES);

    logic [31:0] r_origin_x, r_origin_y;
    logic [7:0]  r_alpha;
    logic [31:0] r_bx, r_by, r_bw, r_bh;
    logic        r_corner;
    logic [6:0]  r_n, r_idx, r_frac, r_drem;
    logic [31:0] r_step, r_phase;
    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic signed [33:0] r_c, r_s;
    logic [63:0] r_mx, r_my;
    logic [31:0] r_ox, r_oy;
    logic        r_out_valid;
    t_ept_out    r_out;

    logic        w_drop, w_thin;
    logic [31:0] w_mn;
    logic [13:0] w_half;
    logic [6:0]  w_n;
    logic [7:0]  w_trial;
    logic        w_ge;
    logic [7:0]  w_fsum;
    logic        w_wrap;
    logic [60:0] w_zprod;
    logic signed [33:0] w_dx, w_dy, w_c, w_s;
    logic [63:0] w_rx, w_ry;
    logic [31:0] w_vx, w_vy;
    logic        w_out_free;

    // input screening and vertex count
    always_comb begin
        w_drop = (r_alpha == 8'd0) || i_in_data.box_w[31] || (i_in_data.box_w == 32'sd0)
              || i_in_data.box_h[31] || (i_in_data.box_h == 32'sd0);
        w_thin = (i_in_data.box_w <= TWO_Q16) || (i_in_data.box_h <= TWO_Q16);
        w_mn   = (i_in_data.box_w < i_in_data.box_h) ? i_in_data.box_w : i_in_data.box_h;
        w_half = w_mn[30:17];
        if (w_half < MIN_N) begin
            w_n = MIN_N[6:0];
        end else if (w_half > MAX_N) begin
            w_n = MAX_N[6:0];
        end else begin
            w_n = w_half[6:0];
        end
    end

    // restoring division of one full turn by n, one quotient bit a cycle
    always_comb begin
        w_trial = {r_drem, (i_cmd.k == 6'd0)};
        w_ge    = w_trial >= {1'b0, r_n};
        w_fsum  = {1'b0, r_frac} + {1'b0, r_drem};
        w_wrap  = w_fsum >= {1'b0, r_n};
        w_zprod = 61'(r_phase[29:0]) * 61'(HALF_PI_Q30);
        w_dx    = r_y >>> i_cmd.k;
        w_dy    = r_x >>> i_cmd.k;
    end

    // quadrant rotation and clamp to unit range
    always_comb begin
        case (r_phase[31:30])
            2'd0: begin w_c = r_x;  w_s = r_y;  end
            2'd1: begin w_c = -r_y; w_s = r_x;  end
            2'd2: begin w_c = -r_x; w_s = -r_y; end
            default: begin w_c = r_y; w_s = -r_x; end
        endcase
        if (w_c > Q30_ONE) w_c = Q30_ONE;
        if (w_c < -Q30_ONE) w_c = -Q30_ONE;
        if (w_s > Q30_ONE) w_s = Q30_ONE;
        if (w_s < -Q30_ONE) w_s = -Q30_ONE;
    end

    always_comb begin
        w_rx = r_mx + 64'h4000_0000;
        w_ry = r_my + 64'h4000_0000;
        if (r_corner) begin
            w_vx = (r_idx[1:0] == 2'd1 || r_idx[1:0] == 2'd2) ? r_bx + r_bw : r_bx;
            w_vy = r_idx[1] ? r_by + r_bh : r_by;
        end else begin
            w_vx = r_bx + r_ox;
            w_vy = r_by + r_oy;
        end
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_alpha    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                REG_ALPHA:    r_alpha    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_box) begin
            r_bx     <= i_in_data.box_x;
            r_by     <= i_in_data.box_y;
            r_bw     <= i_in_data.box_w;
            r_bh     <= i_in_data.box_h;
            r_corner <= w_thin;
            r_n      <= w_thin ? 7'd4 : w_n;
            r_idx    <= '0;
            r_phase  <= '0;
            r_frac   <= '0;
            r_drem   <= '0;
            r_step   <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= w_ge ? 7'(w_trial - {1'b0, r_n}) : w_trial[6:0];
            r_step <= {r_step[30:0], w_ge};
        end
        if (i_cmd.zmul) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= 32'(w_zprod[60:30]);
        end
        if (i_cmd.cordic_step) begin
            if (!r_z[31]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_q30(i_cmd.k[4:0]);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_q30(i_cmd.k[4:0]);
            end
        end
        if (i_cmd.rot) begin
            r_c <= w_c;
            r_s <= w_s;
        end
        if (i_cmd.mul) begin
            r_mx <= 64'(r_bw) * 64'(r_c + Q30_ONE);
            r_my <= 64'(r_bh) * 64'(r_s + Q30_ONE);
        end
        if (i_cmd.off) begin
            r_ox <= w_rx[62:31];
            r_oy <= w_ry[62:31];
        end
        if (i_cmd.emit) begin
            r_out.vertex_x      <= w_vx + r_origin_x;
            r_out.vertex_y      <= w_vy + r_origin_y;
            r_out.vertex_number <= r_idx[5:0];
            r_out.last_vertex   <= (r_idx == r_n - 7'd1);
            r_idx   <= r_idx + 7'd1;
            r_frac  <= w_wrap ? 7'(w_fsum - {1'b0, r_n}) : w_fsum[6:0];
            r_phase <= r_phase + r_step + 32'(w_wrap);
        end
    end

    assign o_stat.drop     = w_drop;
    assign o_stat.thin     = w_thin;
    assign o_stat.corner   = r_corner;
    assign o_stat.last     = (r_idx == r_n - 7'd1);
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ----- tb/tb_ellipse_polygon_tessellator.sv -----
// self-checking testbench of the ellipse polygon tessellator
module tb_ellipse_polygon_tessellator;
    import ept_pkg::*;

    // register index that maps to no register
    localparam logic [1:0] REG_NONE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_ept_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_ept_out    o_out_data;

    ellipse_polygon_tessellator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    // local copy of the registers the predictor uses
    logic [31:0] org_x, org_y;
    logic [7:0]  alpha;

    t_ept_in  box_queue[$];
    t_ept_out vertex_queue[$];
    int       mismatches = 0;
    int       vertices_seen = 0;
    int       boxes_sent = 0;
    int       hold_cycles = 0;
    bit       in_wait_set = 0;
    int       in_wait = 0;
    int       out_wait = 0;
    int       cfg_sets = 0;

    always #4 i_clk = ~i_clk;

    // append a box to the pending requests
    task automatic add_box(input t_ept_in b);
        box_queue = {box_queue, b};
    endtask

    // append an expected vertex
    task automatic add_vertex(input t_ept_out v);
        vertex_queue = {vertex_queue, v};
    endtask

    // arctangent steps of the rotation, Q30 radians
    function automatic longint atan_step(int k);
        longint t[30] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
        return t[k];
    endfunction

    // cosine and sine of a fraction of a turn, Q30, clamped to +-1
    task automatic turn_sincos(input logic [31:0] phase, output longint c, output longint s);
        longint x, y, z, dx, dy, unit;
        unit = 64'sd1073741824;
        z = longint'((64'(phase[29:0]) * 64'd1686629713) >> 30);
        x = 652032874;
        y = 0;
        for (int k = 0; k < 30; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(k);
            end else begin
                x += dx; y -= dy; z += atan_step(k);
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        if (c > unit) c = unit;
        if (c < -unit) c = -unit;
        if (s > unit) s = unit;
        if (s < -unit) s = -unit;
    endtask

    function automatic t_ept_out make_vertex(logic [31:0] vx, logic [31:0] vy, int k, int n);
        t_ept_out v;
        v.vertex_x = vx + org_x;
        v.vertex_y = vy + org_y;
        v.vertex_number = 6'(k);
        v.last_vertex = (k == n - 1);
        return v;
    endfunction

    // expected polygon of one box
    task automatic predict_polygon(input t_ept_in b);
        longint w, h, mn, n, c, s;
        logic [63:0] ox, oy;
        logic [31:0] phase;
        w = longint'(b.box_w);
        h = longint'(b.box_h);
        if (alpha == 0 || w <= 0 || h <= 0) return;
        if (w <= 64'h20000 || h <= 64'h20000) begin
            // thin box: four corners
            add_vertex(make_vertex(b.box_x, b.box_y, 0, 4));
            add_vertex(make_vertex(b.box_x + b.box_w, b.box_y, 1, 4));
            add_vertex(make_vertex(b.box_x + b.box_w, b.box_y + b.box_h, 2, 4));
            add_vertex(make_vertex(b.box_x, b.box_y + b.box_h, 3, 4));
            return;
        end
        mn = (w < h) ? w : h;
        n = (mn >>> 16) / 2;
        if (n < 4) n = 4;
        if (n > 64) n = 64;
        for (int i = 0; i < n; i++) begin
            phase = 32'((64'(i) << 32) / 64'(n));
            turn_sincos(phase, c, s);
            ox = (64'(w) * 64'(64'sd1073741824 + c) + 64'd1073741824) >> 31;
            oy = (64'(h) * 64'(64'sd1073741824 + s) + 64'd1073741824) >> 31;
            add_vertex(make_vertex(b.box_x + ox[31:0], b.box_y + oy[31:0], i, int'(n)));
        end
    endtask

    // driver: one request at a time from the pending queue, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the request until it is taken
        end else begin
            if (i_in_valid) begin
                predict_polygon(i_in_data);
                boxes_sent++;
            end
            if (!in_wait_set && box_queue.size() > 0) begin
                in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
                in_wait_set = 1;
            end
            if (in_wait_set && in_wait > 0) begin
                in_wait--;
                i_in_valid <= 1'b0;
            end else if (in_wait_set) begin
                i_in_data  <= box_queue.pop_front();
                i_in_valid <= 1'b1;
                in_wait_set = 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare every vertex with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            vertices_seen++;
            if (vertex_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex %p", o_out_data);
            end else begin
                t_ept_out e;
                e = vertex_queue.pop_front();
                if (e !== o_out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: expected %p got %p", e, o_out_data);
                end
            end
        end
    end

    // receiver stalls, with one long hold-off window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            out_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X: org_x = val;
            REG_ORIGIN_Y: org_y = val;
            REG_ALPHA:    alpha = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] a);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ALPHA, a);
        cfg_sets++;
    endtask

    // wait until every request went in and every vertex came out, then a latency margin
    task automatic drain();
        while (box_queue.size() > 0 || i_in_valid || in_wait_set || vertex_queue.size() > 0)
            @(posedge i_clk);
        repeat (2400) @(posedge i_clk);
    endtask

    function automatic t_ept_in mk_box(logic [31:0] x, logic [31:0] y,
                                       logic [31:0] w, logic [31:0] h);
        t_ept_in b;
        b.box_x = x; b.box_y = y; b.box_w = w; b.box_h = h;
        return b;
    endfunction

    // random box: mostly small ellipses, some thin, empty and huge ones
    function automatic t_ept_in rand_box();
        logic [31:0] x, y, w, h;
        int kind;
        x = $urandom;
        y = $urandom;
        if ($urandom_range(0, 1)) begin
            x = $signed(x) >>> $urandom_range(0, 12);
            y = $signed(y) >>> $urandom_range(0, 12);
        end
        kind = $urandom_range(0, 19);
        if (kind < 11) begin
            w = $urandom_range(32'h2_0001, 32'h18_0000);
            h = $urandom_range(32'h2_0001, 32'h18_0000);
        end else if (kind < 14) begin
            w = $urandom_range(1, 32'h2_0000);
            h = $urandom_range(1, 32'h40_0000);
            if ($urandom_range(0, 1)) {w, h} = {h, w};
        end else if (kind < 16) begin
            w = $urandom;
            h = $urandom;
            if ($urandom_range(0, 1)) w[31] = 1'b1; else h[31] = 1'b1;
        end else if (kind < 18) begin
            w = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 32'h10_0000);
            h = (w == 0) ? $urandom : 32'd0;
        end else begin
            // large boxes: full 64 vertices
            w = {1'b0, 31'($urandom)} | 32'h80_0000;
            h = {1'b0, 31'($urandom)} | 32'h80_0000;
        end
        return mk_box(x, y, w, h);
    endfunction

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_ORIGIN_X;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_ready = 0;
        org_x = 0; org_y = 0; alpha = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // reset alpha is zero: nothing comes out
        add_box(mk_box(0, 0, 32'h10_0000, 32'h10_0000));
        drain();

        set_config(0, 0, 255);
        add_box(mk_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_box(mk_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h10_0000));
        add_box(mk_box(5, 7, 32'h10_0000, 0));
        add_box(mk_box(5, 7, 32'h2_0000, 32'h2_0000));
        add_box(mk_box(32'hFFFF_0000, 3, 1, 32'h7FFF_FFFF));
        add_box(mk_box(32'h7FFF_0000, 32'h7FFF_0000, 32'h2_0001, 32'h2_0001));
        add_box(mk_box(0, 0, 32'h8_0000, 32'h8_0000));
        add_box(mk_box(0, 0, 32'h9_FFFF, 32'hA_0000));
        add_box(mk_box(32'h1234_5678, 32'h8765_4321, 32'h30_0000, 32'h40_0000));
        add_box(mk_box(0, 0, 32'h80_0000, 32'h81_0000));
        add_box(mk_box(0, 0, 32'hFFFF_FFFF, 32'h10_0000));
        drain();

        set_config(32'h7FFF_FFFF, 32'h8000_0000, 1);
        add_box(mk_box(32'h1_0000, 32'hFFFF_0000, 32'h6_0000, 32'h1_0000));
        add_box(mk_box(32'hFFFF_FFFF, 0, 32'h20_0000, 32'h20_0000));
        // receiver holds off long while boxes keep coming, so the input stalls
        hold_cycles = 600;
        for (int i = 0; i < 8; i++) add_box(rand_box());
        drain();

        // random phases through several register settings
        for (int p = 0; p < 6; p++) begin
            set_config($urandom, $urandom, (p == 2) ? 0 : $urandom_range(1, 255));
            if (p == 3) write_reg(REG_NONE, $urandom);
            for (int i = 0; i < 48; i++) add_box(rand_box());
            drain();
        end

        $display("boxes sent: %0d, vertices checked: %0d, register settings: %0d",
                 boxes_sent, vertices_seen, cfg_sets);
        $display("covered empty, thin, clamped and wrapping boxes under long output stalls");
        if (mismatches == 0 && vertex_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
